>>> src/bcm_pkg.sv
// Shared constants, types and multiplier latency for the binomial coefficient block.
package bcm_pkg;

   localparam int VAL_W = 30;
   localparam int ARG_W = 12;
   localparam logic [VAL_W-1:0] PRIME = 30'd998244353;
   // Barrett factor: floor(2^60 / p), fits in 31 bits.
   localparam logic [63:0] MU_WIDE = (64'd1 << 60) / 64'd998244353;
   localparam logic [30:0] MU = MU_WIDE[30:0];
   // Exponent for the Fermat inverse, p - 2.
   localparam logic [VAL_W-1:0] INV_EXP = 30'd998244351;
   localparam int MUL_LAT = 4;

   typedef struct packed {
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             fact_we;
      logic             invf_we;
      logic [VAL_W-1:0] data;
   } tbl_wr_type;

endpackage

>>> src/bcm_ram.sv
// Generic single-write, single-read memory with a registered read.
module bcm_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/bcm_modmul.sv
// Four-stage pipelined multiplier modulo p with Barrett reduction.
module bcm_modmul
   import bcm_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [VAL_W-1:0] a,
   input  logic [VAL_W-1:0] b,
   output logic [VAL_W-1:0] product
);

   logic [59:0]      prod_ff, prod_in;
   logic [31:0]      low_b_ff, low_b_in;
   logic [61:0]      t_ff, t_in;
   logic [31:0]      low_c_ff, low_c_in;
   logic [31:0]      qp_ff, qp_in;
   logic [VAL_W-1:0] res_ff, res_in;
   logic [60:0]      qp_full;
   logic [31:0]      r;
   logic [31:0]      p32;

   assign p32 = {2'b00, PRIME};

   always_comb begin
      prod_in  = 60'(a) * 60'(b);
      t_in     = 62'(prod_ff[59:29]) * 62'(MU);
      low_b_in = prod_ff[31:0];
      qp_full  = 61'(t_ff[61:31]) * 61'(PRIME);
      qp_in    = qp_full[31:0];
      low_c_in = low_b_ff;
      // The estimate leaves a remainder below three times p.
      r = low_c_ff - qp_ff;
      if (r >= (p32 << 1)) begin
         res_in = VAL_W'(r - (p32 << 1));
      end else if (r >= p32) begin
         res_in = VAL_W'(r - p32);
      end else begin
         res_in = VAL_W'(r);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         t_ff     <= t_in;
         low_b_ff <= low_b_in;
         qp_ff    <= qp_in;
         low_c_ff <= low_c_in;
         res_ff   <= res_in;
      end
   end

   assign product = res_ff;

endmodule

>>> src/bcm_init.sv
// Table fill sequencer: factorials, one Fermat inverse, then inverse factorials downward.
module bcm_init
   import bcm_pkg::*;
#(
   parameter int TABLE_SIZE = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [VAL_W-1:0]              mul_result,
   output mul_req_type                   mul_req,
   output tbl_wr_type                    tbl_wr,
   output logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
   output logic                          done
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

   localparam logic [3:0] ST_START   = 4'd0;
   localparam logic [3:0] ST_FACT    = 4'd1;
   localparam logic [3:0] ST_FACT_W  = 4'd2;
   localparam logic [3:0] ST_SQ      = 4'd3;
   localparam logic [3:0] ST_SQ_W    = 4'd4;
   localparam logic [3:0] ST_MB      = 4'd5;
   localparam logic [3:0] ST_MB_W    = 4'd6;
   localparam logic [3:0] ST_INVF    = 4'd7;
   localparam logic [3:0] ST_INVF_W  = 4'd8;
   localparam logic [3:0] ST_DONE    = 4'd9;

   logic [3:0]       state_ff, state_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [VAL_W-1:0] acc_ff, acc_in;
   logic [VAL_W-1:0] base_ff, base_in;
   logic [4:0]       bit_ff, bit_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             last_wait;

   assign last_wait = (cnt_ff == 3'd1);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      acc_in     = acc_ff;
      base_in    = base_ff;
      bit_in     = bit_ff;
      cnt_in     = (cnt_ff != 3'd0) ? cnt_ff - 3'd1 : cnt_ff;
      mul_req.a  = acc_ff;
      mul_req.b  = acc_ff;
      tbl_wr     = '0;
      wr_addr    = idx_ff;

      case (state_ff)
         ST_START: begin
            tbl_wr.fact_we = 1'b1;
            tbl_wr.data    = VAL_W'(1);
            wr_addr        = '0;
            acc_in         = VAL_W'(1);
            idx_in         = AW'(1);
            state_in       = ST_FACT;
         end
         ST_FACT: begin
            mul_req.b = VAL_W'(idx_ff);
            cnt_in    = 3'(MUL_LAT);
            state_in  = ST_FACT_W;
         end
         ST_FACT_W: begin
            if (last_wait) begin
               tbl_wr.fact_we = 1'b1;
               tbl_wr.data    = mul_result;
               if (idx_ff == LAST) begin
                  base_in  = mul_result;
                  acc_in   = VAL_W'(1);
                  bit_in   = 5'(VAL_W - 1);
                  state_in = ST_SQ;
               end else begin
                  acc_in   = mul_result;
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_FACT;
               end
            end
         end
         ST_SQ, ST_MB: begin
            if (state_ff == ST_MB) begin
               mul_req.b = base_ff;
               state_in  = ST_MB_W;
            end else begin
               state_in  = ST_SQ_W;
            end
            cnt_in = 3'(MUL_LAT);
         end
         ST_SQ_W, ST_MB_W: begin
            if (last_wait) begin
               acc_in = mul_result;
               if (state_ff == ST_SQ_W && INV_EXP[bit_ff]) begin
                  state_in = ST_MB;
               end else if (bit_ff == 5'd0) begin
                  // Inverse of the largest factorial is ready.
                  tbl_wr.invf_we = 1'b1;
                  tbl_wr.data    = mul_result;
                  wr_addr        = LAST;
                  idx_in         = LAST;
                  state_in       = ST_INVF;
               end else begin
                  bit_in   = bit_ff - 5'd1;
                  state_in = ST_SQ;
               end
            end
         end
         ST_INVF: begin
            mul_req.b = VAL_W'(idx_ff);
            cnt_in    = 3'(MUL_LAT);
            state_in  = ST_INVF_W;
         end
         ST_INVF_W: begin
            if (last_wait) begin
               tbl_wr.invf_we = 1'b1;
               tbl_wr.data    = mul_result;
               wr_addr        = idx_ff - AW'(1);
               acc_in         = mul_result;
               idx_in         = idx_ff - AW'(1);
               state_in       = (idx_ff == AW'(1)) ? ST_DONE : ST_INVF;
            end
         end
         ST_DONE: begin
            state_in = ST_DONE;
         end
         default: begin
            state_in = ST_START;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      idx_ff  <= idx_in;
      acc_ff  <= acc_in;
      base_ff <= base_in;
      bit_ff  <= bit_in;
   end

   assign done = (state_ff == ST_DONE);

endmodule

>>> src/binomial_coefficient_mod_prime.sv
// Top level: n choose k modulo 998244353 from factorial and inverse factorial tables.
//
// After reset the block fills its tables and accepts no word until they are full:
// factorials take TABLE_SIZE-1 multiplies, one Fermat inverse of the largest
// factorial takes 58 multiplies (30 squarings and 28 multiplies by the base), and
// the inverse factorials take another TABLE_SIZE-1, all in the shared modular
// multiplier. From then on one query word is accepted every cycle while the
// result side keeps up. A query reads fact[n] and two inverse factorial copies in
// the same cycle, then runs two chained four-stage modular multipliers and a
// result register.
// The result is zero when k exceeds n or n lies outside the table.
module binomial_coefficient_mod_prime
   import bcm_pkg::*;
#(
   parameter int TABLE_SIZE = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [ARG_W-1:0] req_total_count,
   input  logic [ARG_W-1:0] req_chosen_count,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [VAL_W-1:0] rsp_binomial_value
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int IW = (AW > ARG_W) ? AW : ARG_W;
   localparam int DEPTH = 2 * MUL_LAT;

   mul_req_type      init_mul;
   tbl_wr_type       init_wr;
   logic [AW-1:0]    init_addr;
   logic             tables_ready;

   logic             adv;
   logic             req_fire;
   logic [IW-1:0]    n_ext, k_ext, d_ext;
   logic             zero_q;
   logic [VAL_W-1:0] fact_rd, invf_k_rd, invf_d_rd;
   logic [VAL_W-1:0] mul1_a, mul1_b, mul1_out, mul2_out;

   logic [DEPTH:0]   vld_ff, vld_in;
   logic [DEPTH:0]   zero_ff, zero_in;
   logic [VAL_W-1:0] dly_ff [MUL_LAT];
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;

   // The whole query pipeline moves only when the result register can take a word.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = tables_ready && adv;
   assign req_fire  = req_valid && req_ready;

   assign n_ext  = IW'(req_total_count);
   assign k_ext  = IW'(req_chosen_count);
   assign d_ext  = n_ext - k_ext;
   assign zero_q = (k_ext > n_ext) || ({1'b0, n_ext} >= (IW + 1)'(TABLE_SIZE));

   bcm_init #(.TABLE_SIZE(TABLE_SIZE)) u_init (
      .clock      (clock),
      .reset      (reset),
      .mul_result (mul1_out),
      .mul_req    (init_mul),
      .tbl_wr     (init_wr),
      .wr_addr    (init_addr),
      .done       (tables_ready)
   );

   bcm_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SIZE)) u_fact_ram (
      .clock   (clock),
      .wr_en   (init_wr.fact_we),
      .wr_addr (init_addr),
      .wr_data (init_wr.data),
      .rd_en   (adv),
      .rd_addr (n_ext[AW-1:0]),
      .rd_data (fact_rd)
   );

   // Two copies of the inverse factorials give two independent reads per cycle.
   bcm_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SIZE)) u_invf_k_ram (
      .clock   (clock),
      .wr_en   (init_wr.invf_we),
      .wr_addr (init_addr),
      .wr_data (init_wr.data),
      .rd_en   (adv),
      .rd_addr (k_ext[AW-1:0]),
      .rd_data (invf_k_rd)
   );

   bcm_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SIZE)) u_invf_d_ram (
      .clock   (clock),
      .wr_en   (init_wr.invf_we),
      .wr_addr (init_addr),
      .wr_data (init_wr.data),
      .rd_en   (adv),
      .rd_addr (d_ext[AW-1:0]),
      .rd_data (invf_d_rd)
   );

   // The first multiplier serves the fill sequencer until the tables are ready.
   assign mul1_a = tables_ready ? fact_rd   : init_mul.a;
   assign mul1_b = tables_ready ? invf_k_rd : init_mul.b;

   bcm_modmul u_mul1 (
      .clock   (clock),
      .en      (adv),
      .a       (mul1_a),
      .b       (mul1_b),
      .product (mul1_out)
   );

   bcm_modmul u_mul2 (
      .clock   (clock),
      .en      (adv),
      .a       (mul1_out),
      .b       (dly_ff[MUL_LAT-1]),
      .product (mul2_out)
   );

   always_comb begin
      vld_in       = {vld_ff[DEPTH-1:0], req_fire};
      zero_in      = {zero_ff[DEPTH-1:0], zero_q};
      rsp_valid_in = vld_ff[DEPTH];
      rsp_value_in = zero_ff[DEPTH] ? '0 : mul2_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv) begin
         zero_ff      <= zero_in;
         rsp_value_ff <= rsp_value_in;
         dly_ff[0]    <= invf_d_rd;
         for (int i = 1; i < MUL_LAT; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_binomial_value = rsp_value_ff;

endmodule
